>>> rtl/core/ipmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipmd_pkg
// Shared widths, register indexes, reset values and control types of the
// incremental PI motor duty core.
// ----------------------------------------------------------------------------
package ipmd_pkg;

   localparam int unsigned MV_W         = 12;
   localparam int unsigned ERR_W        = 13;
   localparam int unsigned GAIN_W       = 16;
   localparam int unsigned BIAS_W       = 19;
   localparam int unsigned PCT_W        = 7;
   localparam int unsigned TERM_W       = 32;
   localparam int unsigned PROD_W       = GAIN_W + ERR_W;
   localparam int unsigned ACC_W        = TERM_W + 2;
   localparam int unsigned DUTY_OUT_W   = 14;
   localparam int unsigned DRIVE_OUT_W  = 19;
   localparam int unsigned REQ_DATA_W   = 24;
   localparam int unsigned RSP_FIELDS_W = DUTY_OUT_W + DRIVE_OUT_W + ERR_W;
   localparam int unsigned RSP_DATA_W   = 48;
   localparam int unsigned RSP_PAD_W    = RSP_DATA_W - RSP_FIELDS_W;
   localparam int unsigned CSR_IDX_W    = 3;
   localparam int unsigned CSR_DATA_W   = 32;

   localparam int unsigned DUTY_BITS_DEF = 13;
   localparam int unsigned FRAC_BITS_DEF = 12;

   localparam int unsigned PCT_FULL_INT = 100;
   localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(PCT_FULL_INT);

   localparam logic [CSR_IDX_W-1:0] REG_GAIN_NOW  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_PREV = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BIAS      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DEAD_ZONE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CEILING   = 3'd4;

   localparam logic signed [GAIN_W-1:0] GAIN_NOW_RST  = 16'sd2496;
   localparam logic signed [GAIN_W-1:0] GAIN_PREV_RST = -16'sd2389;
   localparam logic [BIAS_W-1:0]        BIAS_RST      = 19'd184320;
   localparam logic [PCT_W-1:0]         DEAD_ZONE_RST = 7'd45;
   localparam logic [PCT_W-1:0]         CEILING_RST   = 7'd100;

   typedef struct packed {
      logic signed [GAIN_W-1:0] gain_now;
      logic signed [GAIN_W-1:0] gain_prev;
      logic [BIAS_W-1:0]        bias_q12;
      logic [PCT_W-1:0]         dead_zone_pct;
      logic [PCT_W-1:0]         ceiling_pct;
   } cfg_type;

   typedef enum logic [1:0] {
      SEL_NOW,
      SEL_PREV,
      SEL_SCALE
   } mul_sel_type;

   typedef struct packed {
      logic        load_in;
      mul_sel_type mul_sel;
      logic        acc_load;
      logic        term_update;
      logic        drive_load;
      logic        rsp_load;
   } cmd_type;

endpackage

>>> rtl/core/ipmd_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipmd_csr
// Configuration register file: gains, bias, dead zone and ceiling.
// ----------------------------------------------------------------------------
module ipmd_csr import ipmd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_GAIN_NOW:  cfg_in.gain_now      = csr_data[GAIN_W-1:0];
            REG_GAIN_PREV: cfg_in.gain_prev     = csr_data[GAIN_W-1:0];
            REG_BIAS:      cfg_in.bias_q12      = csr_data[BIAS_W-1:0];
            REG_DEAD_ZONE: cfg_in.dead_zone_pct = csr_data[PCT_W-1:0];
            REG_CEILING:   cfg_in.ceiling_pct   = csr_data[PCT_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_now      <= GAIN_NOW_RST;
         cfg_ff.gain_prev     <= GAIN_PREV_RST;
         cfg_ff.bias_q12      <= BIAS_RST;
         cfg_ff.dead_zone_pct <= DEAD_ZONE_RST;
         cfg_ff.ceiling_pct   <= CEILING_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> rtl/core/ipmd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipmd_ctrl
// Sequencer: steps one sample through the shared multiplier and holds the
// result beat valid.
// ----------------------------------------------------------------------------
module ipmd_ctrl import ipmd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_NOW,
      ST_MUL_PREV,
      ST_UPDATE,
      ST_CLAMP,
      ST_SCALE,
      ST_FIX
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in         = state_ff;
      cmd.load_in      = 1'b0;
      cmd.mul_sel      = SEL_NOW;
      cmd.acc_load     = 1'b0;
      cmd.term_update  = 1'b0;
      cmd.drive_load   = 1'b0;
      cmd.rsp_load     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_MUL_NOW;
            end
         end
         ST_MUL_NOW: begin
            cmd.mul_sel = SEL_NOW;
            state_in    = ST_MUL_PREV;
         end
         ST_MUL_PREV: begin
            cmd.mul_sel  = SEL_PREV;
            cmd.acc_load = 1'b1;
            state_in     = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.term_update = 1'b1;
            state_in        = ST_CLAMP;
         end
         ST_CLAMP: begin
            cmd.drive_load = 1'b1;
            state_in       = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.mul_sel = SEL_SCALE;
            state_in    = ST_FIX;
         end
         ST_FIX: begin
            // keep the duty product while the result register is busy
            cmd.mul_sel = SEL_SCALE;
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/core/ipmd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipmd_dp
// Datapath: error, shared multiplier, saturating PI term, dead zone and
// ceiling clamp, duty scaling by reciprocal with one correction step.
// ----------------------------------------------------------------------------
module ipmd_dp import ipmd_pkg::*; #(
   parameter int unsigned DUTY_BITS = DUTY_BITS_DEF,
   parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  cmd_type               cmd,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int unsigned DRV_W    = (FRAC_BITS + PCT_W > DRIVE_OUT_W) ?
                                      FRAC_BITS + PCT_W : DRIVE_OUT_W;
   localparam int unsigned QW       = DUTY_BITS + 1;
   localparam int unsigned SCALE_SH = FRAC_BITS + PCT_W;
   localparam int unsigned QM       = (2 ** (DUTY_BITS + PCT_W)) / PCT_FULL_INT;
   localparam int unsigned QM_W     = $clog2(QM + 1);
   localparam int unsigned MA_W     = DRV_W + 1;
   localparam int unsigned MB_W     = (QM_W + 1 > ERR_W) ? QM_W + 1 : ERR_W;
   localparam int unsigned P_W      = MA_W + MB_W;
   localparam int unsigned CW       = DRV_W + DUTY_BITS + 2;

   logic signed [ERR_W-1:0]  err_ff;
   logic signed [ERR_W-1:0]  last_err_ff;
   logic signed [TERM_W-1:0] term_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [P_W-1:0]    prod_ff;
   logic [DRV_W-1:0]         drive_ff;
   logic [RSP_DATA_W-1:0]    rsp_tdata_ff;

   logic [MV_W-1:0]          sp;
   logic [MV_W-1:0]          ms;
   logic signed [MA_W-1:0]   mul_a;
   logic signed [MB_W-1:0]   mul_b;
   logic signed [P_W-1:0]    prod_in;
   logic signed [PROD_W-1:0] gprod;
   logic signed [ACC_W-1:0]  sum;
   logic signed [TERM_W-1:0] term_sat;
   logic signed [ACC_W-1:0]  bias_s;
   logic signed [ACC_W-1:0]  term_s;
   logic signed [ACC_W-1:0]  dsum;
   logic signed [ACC_W-1:0]  dz_s;
   logic signed [ACC_W-1:0]  ceil_s;
   logic [PCT_W-1:0]         ceil_pct;
   logic [DRV_W-1:0]         drive_in;
   logic [QW-1:0]            q0;
   logic [QW:0]              q1;
   logic [CW-1:0]            numer;
   logic [CW-1:0]            chk;
   logic [QW-1:0]            duty_fix;
   logic [31:0]              duty_x;

   assign sp = req_tdata[MV_W-1:0];
   assign ms = req_tdata[2*MV_W-1:MV_W];

   always_comb begin
      case (cmd.mul_sel)
         SEL_NOW: begin
            mul_a = MA_W'(cfg.gain_now);
            mul_b = MB_W'(err_ff);
         end
         SEL_PREV: begin
            mul_a = MA_W'(cfg.gain_prev);
            mul_b = MB_W'(last_err_ff);
         end
         SEL_SCALE: begin
            mul_a = MA_W'(drive_ff);
            mul_b = MB_W'(QM);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;
   assign gprod   = prod_ff[PROD_W-1:0];
   assign sum     = acc_ff + ACC_W'(gprod);

   // saturate to signed 32 bits
   always_comb begin
      if ((~|sum[ACC_W-1:TERM_W-1]) || (&sum[ACC_W-1:TERM_W-1])) begin
         term_sat = sum[TERM_W-1:0];
      end else if (sum[ACC_W-1]) begin
         term_sat = {1'b1, {(TERM_W-1){1'b0}}};
      end else begin
         term_sat = {1'b0, {(TERM_W-1){1'b1}}};
      end
   end

   assign ceil_pct = (cfg.ceiling_pct > PCT_FULL) ? PCT_FULL : cfg.ceiling_pct;
   assign bias_s   = ACC_W'(cfg.bias_q12);
   assign term_s   = ACC_W'(term_ff);
   assign dsum     = bias_s + term_s;
   assign dz_s     = ACC_W'(cfg.dead_zone_pct) << FRAC_BITS;
   assign ceil_s   = ACC_W'(ceil_pct) << FRAC_BITS;

   always_comb begin
      if (dsum < dz_s) begin
         drive_in = '0;
      end else if (dsum > ceil_s) begin
         drive_in = ceil_s[DRV_W-1:0];
      end else begin
         drive_in = dsum[DRV_W-1:0];
      end
   end

   // reciprocal estimate is exact or one short
   assign q0       = prod_ff[SCALE_SH +: QW];
   assign q1       = (QW + 1)'(q0) + 1'b1;
   assign numer    = CW'(drive_ff) << DUTY_BITS;
   assign chk      = (CW'(q1) * CW'(PCT_FULL_INT)) << FRAC_BITS;
   assign duty_fix = (numer >= chk) ? q1[QW-1:0] : q0;
   assign duty_x   = 32'(duty_fix);

   always_ff @(posedge clock) begin
      if (reset) begin
         term_ff     <= '0;
         last_err_ff <= '0;
      end else if (cmd.term_update) begin
         term_ff     <= term_sat;
         last_err_ff <= err_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (cmd.load_in) begin
         err_ff <= ERR_W'(sp) - ERR_W'(ms);
      end
      if (cmd.acc_load) begin
         acc_ff <= ACC_W'(term_ff) + ACC_W'(gprod);
      end
      if (cmd.drive_load) begin
         drive_ff <= drive_in;
      end
      if (cmd.rsp_load) begin
         rsp_tdata_ff <= {{RSP_PAD_W{1'b0}}, err_ff, drive_ff[DRIVE_OUT_W-1:0],
                          duty_x[DUTY_OUT_W-1:0]};
      end
   end

   assign rsp_tdata = rsp_tdata_ff;

endmodule

>>> rtl/core/incremental_pi_motor_duty_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// incremental_pi_motor_duty_core
// Velocity-form PI controller turning a setpoint and a measurement into a
// clamped drive percentage and a PWM duty.
// ----------------------------------------------------------------------------
// A request beat passes MUL_NOW, MUL_PREV, UPDATE, CLAMP, SCALE and FIX; FIX
// loads the result register once it is free. One shared multiplier serves the
// two gain products, then the duty reciprocal; a new request is taken only in
// IDLE. The result register lets the next request in while a result waits.
// Reset (synchronous): PI term and previous error cleared, registers to defaults.
module incremental_pi_motor_duty_core import ipmd_pkg::*; #(
   parameter int unsigned DUTY_BITS = DUTY_BITS_DEF,
   parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // setpoint_mv[11:0], measured_mv[23:12]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // duty[13:0], drive_q12[32:14],
                                              // error_mv[45:33], zero pad
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type cfg;
   cmd_type cmd;

   ipmd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ipmd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   ipmd_dp #(
      .DUTY_BITS (DUTY_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata)
   );

endmodule

>>> rtl/core/ipmd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipmd_checker
// Port-level checks of the PI motor duty core, bound to the top level.
// ----------------------------------------------------------------------------
module ipmd_checker import ipmd_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat valid after reset");

   a_one_sample_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while a sample is in work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result beat changed");

   a_zero_drive_zero_duty: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[32:14] == '0)) |-> (rsp_tdata[13:0] == '0))
      else $error("duty non-zero with zero drive");

endmodule

bind incremental_pi_motor_duty_core ipmd_checker u_ipmd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
